FILE: hw/rtl/http_token_or_quoted_string_parser_macros.svh
// Assertion macros for the token or quoted-string parser.
`ifndef HTTP_TOKEN_OR_QUOTED_STRING_PARSER_MACROS_SVH
`define HTTP_TOKEN_OR_QUOTED_STRING_PARSER_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define HTQS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("htqs assertion failed");

// Same-cycle implication.
`define HTQS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("htqs implication failed");

`endif

FILE: hw/rtl/htqs_pkg.sv
// Shared types, constants and character-class functions of the parser.
`timescale 1ns / 1ps
package htqs_pkg;

	localparam int HTQS_QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;

	// Result status codes
	typedef enum logic [2:0] {
		ST_BUSY     = 3'd0,
		ST_QDONE    = 3'd1,
		ST_TDONE    = 3'd2,
		ST_SHORT    = 3'd3,
		ST_BADESC   = 3'd4,
		ST_BADQD    = 3'd5,
		ST_BADTOKEN = 3'd6
	} status_t;

	// Classified request carried from front to back
	typedef struct packed {
		logic       eoi;
		logic [7:0] data_byte;
		logic       tchar;
		logic       qd10;
		logic       qd11;
		logic       pair;
	} item_t;

	// Queue status seen by the top level
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic is_tchar(input logic [7:0] b);
		logic r;
		r = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
		    (b >= 8'h61 && b <= 8'h7A);
		case (b)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
			default: ;
		endcase
		return r;
	endfunction

	// HTTP/1.0 qdtext: printable minus quote, plus CR, LF, HTAB, SP
	function automatic logic is_qd10(input logic [7:0] b);
		return (b == 8'h21) || (b == 8'h09) || (b == 8'h20) ||
		       (b >= 8'h23 && b <= 8'h7E) || (b == 8'h0D) || (b == 8'h0A);
	endfunction

	// HTTP/1.1 qdtext: no backslash, adds obs-text
	function automatic logic is_qd11(input logic [7:0] b);
		return (b == 8'h21) || (b == 8'h09) || (b == 8'h20) ||
		       (b >= 8'h23 && b <= 8'h5B) || (b >= 8'h5D && b <= 8'h7E) || b[7];
	endfunction

	function automatic logic is_pair(input logic [7:0] b);
		return (b == 8'h09) || (b == 8'h20) || (b >= 8'h21 && b <= 8'h7E) || b[7];
	endfunction

endpackage

FILE: hw/rtl/htqs_front.sv
// Front end: takes input requests and tags each byte with its character classes.
`timescale 1ns / 1ps
module htqs_front
	import htqs_pkg::*;
(
	input  logic       in_eoi,
	input  logic [7:0] in_byte,
	output item_t      item
);

	// Character classes for every rule the back end may apply
	always_comb begin
		item.eoi       = in_eoi;
		item.data_byte = in_byte;
		item.tchar     = is_tchar(in_byte);
		item.qd10      = is_qd10(in_byte);
		item.qd11      = is_qd11(in_byte);
		item.pair      = is_pair(in_byte);
	end

endmodule

FILE: hw/rtl/htqs_queue.sv
// Small flip-flop queue between the classifier and the parse engine.
`timescale 1ns / 1ps
module htqs_queue
	import htqs_pkg::*;
#(
	parameter int DEPTH = HTQS_QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   head,
	output q_stat_t stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign head       = mem_q[rd_ptr_q];

	// Storage write
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/htqs_back.sv
// Back end: parse-phase state machine, mode register and output register.
`timescale 1ns / 1ps
module htqs_back
	import htqs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       head_valid,
	input  item_t      head,
	output logic       pop,
	output logic       out_vld,
	input  logic       out_rdy,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output status_t    out_status,
	output logic       out_quoted
);

	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_TOKEN  = 2'd1,
		PH_QUOTED = 2'd2,
		PH_ESCAPE = 2'd3
	} phase_t;

	phase_t     phase_q, nxt_phase;
	logic       http10_q;
	logic       out_vld_q;
	logic       r_valid;
	logic [7:0] r_byte;
	status_t    r_status;
	logic       r_quoted;
	logic       qd;

	// Pop when the output register is free or drains this cycle
	assign pop     = head_valid && (!out_vld_q || out_rdy);
	assign out_vld = out_vld_q;
	assign qd      = http10_q ? head.qd10 : head.qd11;

	// Next phase and result of the head request
	always_comb begin
		nxt_phase = phase_q;
		r_valid   = 1'b0;
		r_byte    = '0;
		r_status  = ST_BUSY;
		r_quoted  = (phase_q == PH_QUOTED) || (phase_q == PH_ESCAPE);
		if (head.eoi) begin
			r_status  = ST_SHORT;
			nxt_phase = PH_START;
		end else begin
			unique case (phase_q)
				PH_START: begin
					if (head.data_byte == CH_DQUOTE) begin
						r_quoted  = 1'b1;
						nxt_phase = PH_QUOTED;
					end else if (head.tchar) begin
						r_valid   = 1'b1;
						r_byte    = head.data_byte;
						nxt_phase = PH_TOKEN;
					end else begin
						r_status = ST_BADTOKEN;
					end
				end
				PH_TOKEN: begin
					if (head.tchar) begin
						r_valid = 1'b1;
						r_byte  = head.data_byte;
					end else begin
						r_status  = ST_TDONE;
						nxt_phase = PH_START;
					end
				end
				PH_QUOTED: begin
					if (qd) begin
						r_valid = 1'b1;
						r_byte  = head.data_byte;
					end else if (!http10_q && head.data_byte == CH_BSLASH) begin
						nxt_phase = PH_ESCAPE;
					end else if (head.data_byte == CH_DQUOTE) begin
						r_status  = ST_QDONE;
						nxt_phase = PH_START;
					end else begin
						r_status  = ST_BADQD;
						nxt_phase = PH_START;
					end
				end
				PH_ESCAPE: begin
					// escape completes under HTTP/1.1 rules whatever the mode
					if (head.pair) begin
						r_valid   = 1'b1;
						r_byte    = head.data_byte;
						nxt_phase = PH_QUOTED;
					end else begin
						r_status  = ST_BADESC;
						nxt_phase = PH_START;
					end
				end
				default: nxt_phase = PH_START;
			endcase
		end
	end

	// State, mode and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_START;
			http10_q   <= 1'b0;
			out_vld_q  <= 1'b0;
			out_valid  <= 1'b0;
			out_byte   <= '0;
			out_status <= ST_BUSY;
			out_quoted <= 1'b0;
		end else begin
			if (cfg_we) begin
				http10_q <= cfg_wdata;
			end
			if (pop) begin
				phase_q    <= nxt_phase;
				out_vld_q  <= 1'b1;
				out_valid  <= r_valid;
				out_byte   <= r_byte;
				out_status <= r_status;
				out_quoted <= r_quoted;
			end else if (out_rdy) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: hw/rtl/http_token_or_quoted_string_parser.sv
// Top level of the HTTP token or quoted-string parser.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one request per byte: tdata is the octet, tuser[0] marks
//   end of available input. m_axis returns exactly one result per request:
//   tdata is the content byte (zero when none), tuser holds out_valid,
//   status and is_quoted. cfg_we/cfg_wdata set the HTTP/1.0 mode bit; write
//   it only while the parser is idle.
//   A request accepted on s_axis is written into the queue and is parsed when
//   the back end pops it; its result is registered in the output register,
//   which drives m_axis. Throughput: one request per cycle while m_axis_tready
//   stays high; each popped request updates the parse phase in the back end.
//   A queue of QUEUE_DEPTH entries sits between classifier and parse engine;
//   s_axis_tready is low only when that queue is full. When m_axis stalls the
//   output register holds its result, the queue fills, and then s_axis stalls.
//   Reset returns the parser to the start phase in HTTP/1.1 mode with the
//   queue and output register empty; there is no clearing pass.
module http_token_or_quoted_string_parser
	import htqs_pkg::*;
#(
	parameter int QUEUE_DEPTH = HTQS_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,  // [0] op (end of input)
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic [4:0] m_axis_tuser   // [0] out_valid, [3:1] status, [4] is_quoted
);

	`include "http_token_or_quoted_string_parser_macros.svh"

	item_t   cls_item, head;
	q_stat_t q_stat;
	logic    push, pop;
	logic    out_valid, out_quoted;
	status_t out_status;

	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && s_axis_tready;
	assign m_axis_tuser  = {out_quoted, out_status, out_valid};

	htqs_front u_front (
		.in_eoi  (s_axis_tuser[0]),
		.in_byte (s_axis_tdata),
		.item    (cls_item)
	);

	htqs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (cls_item),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	htqs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.head_valid (!q_stat.empty),
		.head       (head),
		.pop        (pop),
		.out_vld    (m_axis_tvalid),
		.out_rdy    (m_axis_tready),
		.out_valid  (out_valid),
		.out_byte   (m_axis_tdata),
		.out_status (out_status),
		.out_quoted (out_quoted)
	);

	// Checks
	`HTQS_ASSERT(a_queue_stat, !(q_stat.full && q_stat.empty))
	`HTQS_ASSERT_IMP(a_content_busy, m_axis_tvalid && out_valid, out_status == ST_BUSY)
	`HTQS_ASSERT_IMP(a_no_content_zero, m_axis_tvalid && !out_valid, m_axis_tdata == 8'h00)
	`HTQS_ASSERT_IMP(a_pop_needs_data, pop, !q_stat.empty)

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the HTTP token or quoted-string parser.
`timescale 1ns / 1ps
module tb_top;
	import htqs_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_EOI  = 1'b1;

	localparam logic [7:0] CH_HTAB = 8'h09;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_SP   = 8'h20;

	typedef enum logic [1:0] {
		P_START  = 2'd0,
		P_TOKEN  = 2'd1,
		P_QUOTED = 2'd2,
		P_ESCAPE = 2'd3
	} parse_phase_t;

	typedef enum int {
		CLS_TCHAR,
		CLS_NONTCHAR,
		CLS_QDTEXT,
		CLS_PAIR,
		CLS_NONPAIR
	} octet_cls_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] obyte;
		status_t    status;
		logic       quoted;
	} parse_res_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_wdata = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;
	logic [0:0] s_axis_tuser = 1'b0;
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic [4:0] m_axis_tuser;

	// Model state and expected results
	parse_phase_t parse_phase = P_START;
	logic         mode_10 = 1'b0;
	parse_res_t   pending_results[$];

	int   items_sent = 0;
	int   err_cnt = 0;
	int   quiet_cycles = 0;
	logic src_idle_en = 1'b1;
	logic sink_idle_en = 1'b1;
	logic hold_req = 1'b0;

	http_token_or_quoted_string_parser u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Character classes
	function automatic logic byte_is_tchar(input logic [7:0] b);
		case (b)
			8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
			8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: return 1'b1;
			default: return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
			                (b >= 8'h61 && b <= 8'h7A);
		endcase
	endfunction

	function automatic logic byte_is_qdtext(input logic [7:0] b, input logic old);
		if (b == 8'h21 || b == CH_HTAB || b == CH_SP)
			return 1'b1;
		// HTTP/1.0 keeps backslash and CR/LF, HTTP/1.1 drops backslash, adds obs-text
		if (old)
			return (b >= 8'h23 && b <= 8'h7E) || b == CH_CR || b == CH_LF;
		return (b >= 8'h23 && b <= 8'h5B) || (b >= 8'h5D && b <= 8'h7E) || b >= 8'h80;
	endfunction

	function automatic logic byte_is_pair(input logic [7:0] b);
		return b == CH_HTAB || (b >= CH_SP && b <= 8'h7E) || b >= 8'h80;
	endfunction

	// Next-state and result of the parser for one request
	function automatic parse_res_t parse_step(input logic op, input logic [7:0] b);
		parse_res_t r;
		r.valid  = 1'b0;
		r.obyte  = 8'h00;
		r.status = ST_BUSY;
		r.quoted = (parse_phase == P_QUOTED || parse_phase == P_ESCAPE);
		if (op == OP_EOI) begin
			r.status = ST_SHORT;
			parse_phase = P_START;
		end else begin
			case (parse_phase)
				P_START: begin
					if (b == CH_DQUOTE) begin
						r.quoted = 1'b1;
						parse_phase = P_QUOTED;
					end else if (byte_is_tchar(b)) begin
						r.valid = 1'b1;
						r.obyte = b;
						parse_phase = P_TOKEN;
					end else begin
						r.status = ST_BADTOKEN;
					end
				end
				P_TOKEN: begin
					if (byte_is_tchar(b)) begin
						r.valid = 1'b1;
						r.obyte = b;
					end else begin
						// terminator is reported, not emitted
						r.status = ST_TDONE;
						parse_phase = P_START;
					end
				end
				P_QUOTED: begin
					if (byte_is_qdtext(b, mode_10)) begin
						r.valid = 1'b1;
						r.obyte = b;
					end else if (!mode_10 && b == CH_BSLASH) begin
						parse_phase = P_ESCAPE;
					end else if (b == CH_DQUOTE) begin
						r.status = ST_QDONE;
						parse_phase = P_START;
					end else begin
						r.status = ST_BADQD;
						parse_phase = P_START;
					end
				end
				default: begin
					// pending escape always follows HTTP/1.1 rules
					if (byte_is_pair(b)) begin
						r.valid = 1'b1;
						r.obyte = b;
						parse_phase = P_QUOTED;
					end else begin
						r.status = ST_BADESC;
						parse_phase = P_START;
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] pick_octet(input octet_cls_t cls);
		logic [7:0] b;
		logic       ok;
		do begin
			b = 8'($urandom);
			case (cls)
				CLS_TCHAR:    ok = byte_is_tchar(b);
				CLS_NONTCHAR: ok = !byte_is_tchar(b);
				CLS_QDTEXT:   ok = byte_is_qdtext(b, mode_10);
				CLS_PAIR:     ok = byte_is_pair(b);
				default:      ok = !byte_is_pair(b);
			endcase
		end while (!ok);
		return b;
	endfunction

	function automatic void note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("%0t ns: %s", $realtime, msg);
	endfunction

	// Send one request; entered and left at a falling edge
	task automatic send_item(input logic op, input logic [7:0] octet);
		int gap;
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= octet;
		s_axis_tuser  <= op;
		do @(posedge clk); while (!s_axis_tready);
		pending_results.push_back(parse_step(op, octet));
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and wait for every outstanding result
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic set_http10(input logic v);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we  <= 1'b0;
		mode_10 = v;
	endtask

	// Random value generators
	task automatic send_token();
		int len;
		len = $urandom_range(1, 8);
		repeat (len) send_item(OP_DATA, pick_octet(CLS_TCHAR));
		if ($urandom_range(0, 9) == 0)
			send_item(OP_EOI, 8'($urandom));
		else
			send_item(OP_DATA, pick_octet(CLS_NONTCHAR));
	endtask

	task automatic send_quoted();
		int len;
		int r;
		send_item(OP_DATA, CH_DQUOTE);
		len = $urandom_range(0, 8);
		repeat (len) begin
			r = $urandom_range(0, 19);
			if (r == 0) begin
				// raw byte, may break the value
				send_item(OP_DATA, 8'($urandom));
			end else if (!mode_10 && r <= 4) begin
				send_item(OP_DATA, CH_BSLASH);
				send_item(OP_DATA, pick_octet(r == 1 ? CLS_NONPAIR : CLS_PAIR));
			end else begin
				send_item(OP_DATA, pick_octet(CLS_QDTEXT));
			end
		end
		if ($urandom_range(0, 9) == 0)
			send_item(OP_EOI, 8'($urandom));
		else
			send_item(OP_DATA, CH_DQUOTE);
	endtask

	task automatic send_noise();
		int n;
		n = $urandom_range(1, 4);
		repeat (n)
			send_item(($urandom_range(0, 7) == 0) ? OP_EOI : OP_DATA, 8'($urandom));
	endtask

	// Tests
	task automatic test_tokens();
		send_item(OP_DATA, "A");
		send_item(OP_DATA, 8'h7E);
		send_item(OP_DATA, CH_SP);
		send_item(OP_DATA, 8'h00);
		send_item(OP_DATA, 8'hFF);
		drain_results();
	endtask

	task automatic test_quoted_http11();
		set_http10(1'b0);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_BSLASH);
		send_item(OP_DATA, 8'hFF);
		send_item(OP_DATA, 8'h80);
		send_item(OP_DATA, CH_DQUOTE);
		// bad escape, then bad qdtext
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_BSLASH);
		send_item(OP_DATA, 8'h7F);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_CR);
		drain_results();
	endtask

	task automatic test_end_of_input();
		send_item(OP_EOI, 8'h00);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_BSLASH);
		send_item(OP_EOI, 8'hFF);
		drain_results();
	endtask

	task automatic test_quoted_http10();
		set_http10(1'b1);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_LF);
		send_item(OP_DATA, CH_BSLASH);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, 8'h80);
		drain_results();
	endtask

	// Escape opened under HTTP/1.1, finished after switching to HTTP/1.0
	task automatic test_mode_switch_mid_value();
		set_http10(1'b0);
		send_item(OP_DATA, CH_DQUOTE);
		send_item(OP_DATA, CH_BSLASH);
		set_http10(1'b1);
		send_item(OP_DATA, "A");
		send_item(OP_DATA, CH_BSLASH);
		send_item(OP_DATA, CH_DQUOTE);
		drain_results();
	endtask

	task automatic test_random_phase(input int n_items, input logic mode);
		int target;
		set_http10(mode);
		target = items_sent + n_items;
		while (items_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3:    send_token();
				4, 5, 6, 7, 8: send_quoted();
				default:       send_noise();
			endcase
		end
		drain_results();
	endtask

	// Sink holds off while the sender keeps going, so the input stalls
	task automatic test_backpressure();
		int i;
		src_idle_en = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 10; i++) begin
			if ($urandom_range(0, 1) == 0)
				send_token();
			else
				send_quoted();
		end
		drain_results();
		src_idle_en = 1'b1;
	endtask

	// Receiver: random ready bursts and one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(negedge clk);
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each result with the oldest expectation
	always @(posedge clk) begin : result_check
		parse_res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result: byte=%02h tuser=%02h",
				                     m_axis_tdata, m_axis_tuser));
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tuser[0] !== want.valid || m_axis_tdata !== want.obyte ||
				    m_axis_tuser[3:1] !== want.status || m_axis_tuser[4] !== want.quoted)
					note_error($sformatf({"mismatch: expected valid=%0b byte=%02h ",
					                      "status=%0d quoted=%0b, got valid=%0b byte=%02h ",
					                      "status=%0d quoted=%0b"},
					                     want.valid, want.obyte, want.status, want.quoted,
					                     m_axis_tuser[0], m_axis_tdata, m_axis_tuser[3:1],
					                     m_axis_tuser[4]));
			end
		end
	end

	// Watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_tokens();
		test_quoted_http11();
		test_end_of_input();
		test_quoted_http10();
		test_mode_switch_mid_value();

		test_random_phase(150, 1'b0);
		test_random_phase(150, 1'b1);
		test_backpressure();
		test_random_phase(150, 1'b0);
		test_random_phase(150, 1'b1);

		// closing stretch at full rate
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		test_random_phase(150, 1'($urandom));

		drain_results();
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: http_token_or_quoted_string_parser.f
+incdir+hw/rtl
hw/rtl/htqs_pkg.sv
hw/rtl/htqs_front.sv
hw/rtl/htqs_queue.sv
hw/rtl/htqs_back.sv
hw/rtl/http_token_or_quoted_string_parser.sv
tb/tb_top.sv
